// File: design/lcd4_pkg.sv
// ----------------------------------------------------------------------------
// lcd4_pkg
// Shared types, codes and constants for the 4-bit character LCD sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcd4_pkg;

  // request codes
  typedef enum logic [2:0] {
    CMD_INIT   = 3'd0,
    CMD_ERASE  = 3'd1,
    CMD_CHAR   = 3'd2,
    CMD_CURSOR = 3'd3,
    CMD_WRITE  = 3'd4
  } cmd_e;

  // three steps of one nibble
  typedef enum logic [1:0] {
    PH_SETUP  = 2'd0,
    PH_STROBE = 2'd1,
    PH_SETTLE = 2'd2
  } phase_e;

  localparam int unsigned GLYPH_ROWS_DEF = 8;
  localparam int unsigned NIB_W          = 5;
  localparam int unsigned HOLD_W         = 16;
  localparam int unsigned EXTRA_W        = 13;

  localparam int unsigned S_TDATA_W = 88;
  localparam int unsigned M_TDATA_W = 24;

  localparam logic [HOLD_W-1:0]  IDLE_US   = 16'd50000;
  localparam logic [HOLD_W-1:0]  PULSE_US  = 16'd1;
  localparam logic [HOLD_W-1:0]  SETTLE_US = 16'd40;
  localparam logic [EXTRA_W-1:0] CLEAR_EXTRA_US = 13'd2000;

  localparam logic [7:0] CLEAR_INSTR = 8'h01;
  localparam logic [7:0] CGRAM_INSTR = 8'h40;
  localparam logic [7:0] DDRAM_INSTR = 8'h80;

  localparam logic [NIB_W-1:0] INIT_LAST_NIB = 5'd13;
  localparam logic [NIB_W-1:0] BYTE_LAST_NIB = 5'd1;

  typedef struct packed {
    logic [3:0]         nib;
    logic [EXTRA_W-1:0] extra;
  } init_nib_t;

  // controller -> datapath
  typedef struct packed {
    logic             load;
    logic             emit;
    logic             pre;
    phase_e           phase;
    logic [NIB_W-1:0] nib;
  } lcd4_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic in_known;
    logic in_init;
    logic last_nib;
    logic out_free;
  } lcd4_stat_t;

  // power-up nibble sequence: 8-bit mode three times, 4-bit mode, then
  // function set, display off, clear, entry mode, display on
  function automatic init_nib_t init_nib(input logic [3:0] idx);
    init_nib_t r;
    r.extra = '0;
    r.nib   = 4'h0;
    case (idx)
      4'd0:    begin r.nib = 4'h3; r.extra = 13'd5000; end
      4'd1:    begin r.nib = 4'h3; r.extra = 13'd150;  end
      4'd2:    begin r.nib = 4'h3; r.extra = 13'd150;  end
      4'd3:    begin r.nib = 4'h2; r.extra = 13'd1000; end
      4'd4:    r.nib = 4'h2;
      4'd5:    r.nib = 4'h8;
      4'd6:    r.nib = 4'h0;
      4'd7:    r.nib = 4'h8;
      4'd8:    r.nib = 4'h0;
      4'd9:    begin r.nib = 4'h1; r.extra = CLEAR_EXTRA_US; end
      4'd10:   r.nib = 4'h0;
      4'd11:   r.nib = 4'h6;
      4'd12:   r.nib = 4'h0;
      4'd13:   r.nib = 4'hC;
      default: r.nib = 4'h0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/lcd4_ctrl.sv
// ----------------------------------------------------------------------------
// lcd4_ctrl
// Request sequencer: walks the nibble index and the three steps per nibble.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd4_ctrl
  import lcd4_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  req_valid_i,
  output logic       req_ready_o,
  input  lcd4_stat_t stat_i,
  output lcd4_ctrl_t ctrl_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PRE  = 3'b010,
    ST_RUN  = 3'b100
  } state_e;

  state_e           state_q, state_d;
  phase_e           phase_q, phase_d;
  logic [NIB_W-1:0] nib_q, nib_d;

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    nib_d        = nib_q;
    req_ready_o  = 1'b0;
    ctrl_o.load  = 1'b0;
    ctrl_o.emit  = 1'b0;
    ctrl_o.pre   = 1'b0;
    ctrl_o.phase = phase_q;
    ctrl_o.nib   = nib_q;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          ctrl_o.load = 1'b1;
          phase_d     = PH_SETUP;
          nib_d       = '0;
          // unknown codes are swallowed without output
          if (stat_i.in_known) begin
            state_d = stat_i.in_init ? ST_PRE : ST_RUN;
          end
        end
      end
      ST_PRE: begin
        if (stat_i.out_free) begin
          ctrl_o.emit = 1'b1;
          ctrl_o.pre  = 1'b1;
          state_d     = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat_i.out_free) begin
          ctrl_o.emit = 1'b1;
          case (phase_q)
            PH_SETUP:  phase_d = PH_STROBE;
            PH_STROBE: phase_d = PH_SETTLE;
            PH_SETTLE: begin
              phase_d = PH_SETUP;
              if (stat_i.last_nib) begin
                state_d = ST_IDLE;
              end else begin
                nib_d = nib_q + NIB_W'(1);
              end
            end
            default:   phase_d = PH_SETUP;
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_SETUP;
      nib_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      nib_q   <= nib_d;
    end
  end

endmodule

`default_nettype wire

// File: design/lcd4_datapath.sv
// ----------------------------------------------------------------------------
// lcd4_datapath
// Request register, nibble and timing selection, and the output step register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd4_datapath
  import lcd4_pkg::*;
#(
  parameter int unsigned GlyphRows = GLYPH_ROWS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [2:0]            cmd_i,
  input  wire logic [7:0]            arg_i,
  input  wire logic [7:0]            row_i,
  input  wire logic [63:0]           bitmap_i,
  input  lcd4_ctrl_t                 ctrl_i,
  output lcd4_stat_t                 stat_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       reg_select_o,
  output logic [3:0]                 data_nibble_o,
  output logic                       enable_o,
  output logic [HOLD_W-1:0]          hold_us_o,
  output logic                       last_o
);

  localparam logic [NIB_W-1:0] CharLastNib = NIB_W'(2 * GlyphRows + 1);

  cmd_e        cmd_q;
  logic [7:0]  arg_q;
  logic        row_nz_q;
  logic [63:0] bitmap_q;

  logic        valid_q, valid_d;
  logic        rs_q;
  logic [3:0]  nib_q;
  logic        en_q;
  logic [HOLD_W-1:0] hold_q;
  logic        last_q;

  logic [3:0]         byte_idx;
  logic [2:0]         row_sel;
  logic [2:0]         glyph_idx;
  logic [3:0]         col;
  logic [7:0]         byte_val;
  logic               rs_val;
  logic [3:0]         nib_val;
  logic [EXTRA_W-1:0] extra;
  logic [NIB_W-1:0]   last_nib_idx;
  logic [HOLD_W-1:0]  hold_val;
  init_nib_t          init_ent;

  // status to the controller: incoming code decode, used in the accept cycle, last nibble and output free
  always_comb begin
    stat_o.in_known = 1'b0;
    stat_o.in_init  = 1'b0;
    stat_o.last_nib = (ctrl_i.nib == last_nib_idx);
    stat_o.out_free = !valid_q || out_ready_i;
    case (cmd_i)
      CMD_INIT:   begin stat_o.in_known = 1'b1; stat_o.in_init = 1'b1; end
      CMD_ERASE,
      CMD_CHAR,
      CMD_CURSOR,
      CMD_WRITE:  stat_o.in_known = 1'b1;
      default:    stat_o.in_known = 1'b0;
    endcase
  end

  assign byte_idx  = ctrl_i.nib[4:1];
  assign row_sel   = 3'(byte_idx - 4'd1);
  assign glyph_idx = (arg_q > 8'd7) ? 3'd7 : arg_q[2:0];
  assign col       = (arg_q > 8'd15) ? 4'd15 : arg_q[3:0];
  assign init_ent  = init_nib(ctrl_i.nib[3:0]);

  always_comb begin
    byte_val     = arg_q;
    rs_val       = 1'b0;
    extra        = '0;
    last_nib_idx = BYTE_LAST_NIB;
    case (cmd_q)
      CMD_INIT:   last_nib_idx = INIT_LAST_NIB;
      CMD_ERASE: begin
        byte_val = CLEAR_INSTR;
        extra    = ctrl_i.nib[0] ? CLEAR_EXTRA_US : '0;
      end
      CMD_CHAR: begin
        last_nib_idx = CharLastNib;
        if (byte_idx == 4'd0) begin
          byte_val = CGRAM_INSTR | {2'b00, glyph_idx, 3'b000};
        end else begin
          byte_val = bitmap_q[{row_sel, 3'b000} +: 8];
          rs_val   = 1'b1;
        end
      end
      // line two base is 0x40, column stays below 16
      CMD_CURSOR: byte_val = DDRAM_INSTR | {1'b0, row_nz_q, 2'b00, col};
      CMD_WRITE:  rs_val   = 1'b1;
      default:    byte_val = arg_q;
    endcase
  end

  always_comb begin
    if (cmd_q == CMD_INIT) begin
      nib_val = init_ent.nib;
    end else begin
      nib_val = ctrl_i.nib[0] ? byte_val[3:0] : byte_val[7:4];
    end
  end

  always_comb begin
    case (ctrl_i.phase)
      PH_SETTLE: begin
        hold_val = SETTLE_US
                 + HOLD_W'((cmd_q == CMD_INIT) ? init_ent.extra : extra);
      end
      default:   hold_val = PULSE_US;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.emit) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q    <= cmd_e'(cmd_i);
      arg_q    <= arg_i;
      row_nz_q <= (row_i != 8'd0);
      bitmap_q <= bitmap_i;
    end
    if (ctrl_i.emit) begin
      if (ctrl_i.pre) begin
        rs_q   <= 1'b0;
        nib_q  <= 4'h0;
        en_q   <= 1'b0;
        hold_q <= IDLE_US;
        last_q <= 1'b0;
      end else begin
        rs_q   <= rs_val;
        nib_q  <= nib_val;
        en_q   <= (ctrl_i.phase == PH_STROBE);
        hold_q <= hold_val;
        last_q <= (ctrl_i.phase == PH_SETTLE) && stat_o.last_nib;
      end
    end
  end

  assign out_valid_o   = valid_q;
  assign reg_select_o  = rs_q;
  assign data_nibble_o = nib_q;
  assign enable_o      = en_q;
  assign hold_us_o     = hold_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

// File: design/char_lcd_4bit_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_4bit_sequencer
// Turns one character LCD request into the pin steps of a 4-bit bus.
// ----------------------------------------------------------------------------
// Slave stream takes a request (init, clear, create glyph, set cursor, write
// data); master stream gives one pin step per item: register select, D7..D4,
// enable level and the time in us to hold them. tlast marks a request's
// final step. Requests with an unknown code are taken and give no steps.
// A taken request is captured in the request register, and its first step
// is then built from it and registered in the output step register.
// Throughput: one step per cycle while the receiver keeps tready high; the
// controller handles one request at a time, so the next request waits until
// the current one has issued its final step. The step counter sets the pace.
// A stalled receiver freezes the step in the output register and the
// sequence behind it; no step is dropped. tready comes back while the final
// step may still sit in the output register.
// Reset clears the controller and the output valid; the block is ready for
// a request right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_4bit_sequencer
  import lcd4_pkg::*;
#(
  parameter int unsigned GlyphRows = GLYPH_ROWS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // cmd[2:0], arg[10:3], row[18:11], bitmap[82:19], zero fill[87:83]
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // reg_select[0], data_nibble[4:1], enable[5], hold_us[21:6], zero fill[23:22]
  output logic [M_TDATA_W-1:0]      m_axis_tdata_o,
  output logic                      m_axis_tlast_o
);

  lcd4_ctrl_t        ctrl;
  lcd4_stat_t        stat;
  logic              rs;
  logic [3:0]        nib;
  logic              en;
  logic [HOLD_W-1:0] hold;

  lcd4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  lcd4_datapath #(
    .GlyphRows (GlyphRows)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (s_axis_tdata_i[2:0]),
    .arg_i         (s_axis_tdata_i[10:3]),
    .row_i         (s_axis_tdata_i[18:11]),
    .bitmap_i      (s_axis_tdata_i[82:19]),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .reg_select_o  (rs),
    .data_nibble_o (nib),
    .enable_o      (en),
    .hold_us_o     (hold),
    .last_o        (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, hold, en, nib, rs};

endmodule

`default_nettype wire

// File: design/lcd4_checker.sv
// ----------------------------------------------------------------------------
// lcd4_checker
// Port-level checks for the 4-bit character LCD sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd4_checker
  import lcd4_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_tvalid_i,
  input wire logic                 s_tready_i,
  input wire logic [S_TDATA_W-1:0] s_tdata_i,
  input wire logic                 m_tvalid_i,
  input wire logic                 m_tready_i,
  input wire logic [M_TDATA_W-1:0] m_tdata_i,
  input wire logic                 m_tlast_i
);

  logic s_acc;
  logic s_known;

  assign s_acc   = s_tvalid_i && s_tready_i;
  assign s_known = (s_tdata_i[2:0] == CMD_INIT) || (s_tdata_i[2:0] == CMD_ERASE)
                || (s_tdata_i[2:0] == CMD_CHAR) || (s_tdata_i[2:0] == CMD_CURSOR)
                || (s_tdata_i[2:0] == CMD_WRITE);

  // a stalled step holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) && $stable(m_tlast_i))
    else $error("stalled step changed");

  // a known request keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_known |=> !s_tready_i)
    else $error("ready right after a known request");

  // an unknown request is dropped and the block stays ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && !s_known |=> s_tready_i)
    else $error("unknown request made the block busy");

  // the final step is a settle step with enable low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tlast_i |-> !m_tdata_i[5] && (m_tdata_i[21:6] >= SETTLE_US))
    else $error("final step is not a settle step");

  // the enable strobe lasts one pulse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tdata_i[5] |-> (m_tdata_i[21:6] == PULSE_US) && !m_tlast_i)
    else $error("enable high step with wrong hold");

endmodule

bind char_lcd_4bit_sequencer lcd4_checker u_lcd4_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .s_tdata_i  (s_axis_tdata_i),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tlast_i  (m_axis_tlast_o)
);

`default_nettype wire

// File: sim/char_lcd_4bit_sequencer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_4bit_sequencer_test
// Self-checking bench for the 4-bit character LCD sequencer. Requests go in
// on the slave stream, first from a short table of corner cases and then at
// random. Every accepted request is expanded into the pin steps it should
// produce. Each step on the master stream is checked against the oldest
// expected step. The receiver stalls and the sender leaves gaps at several
// rates.
// ----------------------------------------------------------------------------

module char_lcd_4bit_sequencer_test;
  import lcd4_pkg::*;

  // command codes the block takes and drops without output
  localparam logic [2:0] CMD_UNUSED_LO  = 3'd5;
  localparam logic [2:0] CMD_UNUSED_MID = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI  = 3'd7;

  // power-up sequence
  localparam logic [3:0]  WAKE_NIB      = 4'h3;
  localparam logic [3:0]  BUS4_NIB      = 4'h2;
  localparam logic [15:0] WAKE1_EXTRA   = 16'd5000;
  localparam logic [15:0] WAKE2_EXTRA   = 16'd150;
  localparam logic [15:0] BUS4_EXTRA    = 16'd1000;
  localparam logic [7:0]  FUNC_SET      = 8'h28;
  localparam logic [7:0]  DISPLAY_OFF   = 8'h08;
  localparam logic [7:0]  ENTRY_MODE    = 8'h06;
  localparam logic [7:0]  DISPLAY_ON    = 8'h0C;

  localparam logic [2:0]  GLYPH_IDX_MAX = 3'd7;
  localparam logic [3:0]  COL_MAX       = 4'd15;
  localparam logic [6:0]  LINE2_BASE    = 7'h40;
  localparam logic        RS_INSTR      = 1'b0;
  localparam logic        RS_DATA       = 1'b1;

  localparam int unsigned ITEMS_PER_PHASE = 110;
  localparam int unsigned STALL_LIMIT     = 4000;
  localparam int unsigned DRAIN_CYCLES    = 64;
  localparam int unsigned SENDER_PCT [4]  = '{0, 45, 0, 14};
  localparam int unsigned SINK_PCT [4]    = '{0, 0, 45, 14};

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  arg;
    logic [7:0]  row;
    logic [63:0] bitmap;
  } lcd_req_t;

  typedef struct packed {
    logic        rs;
    logic [3:0]  nib;
    logic        en;
    logic [15:0] hold;
    logic        last;
  } pin_step_t;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_BYTE,
    CHK_NONE
  } chk_kind_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  arg;
    logic [7:0]  row;
    logic [63:0] bitmap;
    chk_kind_e   kind;
    logic        want_rs;
    logic [7:0]  want_byte;
    logic [15:0] want_extra;
  } stim_row_t;

  localparam int unsigned STIM_ROWS = 20;
  localparam stim_row_t STIM_TABLE [STIM_ROWS] = '{
    '{CMD_INIT,   8'h00, 8'h00, 64'h0, CHK_MODEL, RS_INSTR, 8'h00, 16'd0},
    '{CMD_ERASE,  8'h00, 8'h00, 64'h0, CHK_BYTE, RS_INSTR, CLEAR_INSTR, 16'(CLEAR_EXTRA_US)},
    '{CMD_WRITE,  8'h00, 8'h00, 64'h0, CHK_BYTE, RS_DATA, 8'h00, 16'd0},
    '{CMD_WRITE,  8'hFF, 8'h00, 64'h0, CHK_BYTE, RS_DATA, 8'hFF, 16'd0},
    '{CMD_WRITE,  8'hA5, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, CHK_MODEL, RS_INSTR, 8'h00, 16'd0},
    '{CMD_CURSOR, 8'h00, 8'h00, 64'h0, CHK_BYTE, RS_INSTR, 8'h80, 16'd0},
    '{CMD_CURSOR, 8'h0F, 8'h01, 64'h0, CHK_BYTE, RS_INSTR, 8'hCF, 16'd0},
    '{CMD_CURSOR, 8'h10, 8'h00, 64'h0, CHK_BYTE, RS_INSTR, 8'h8F, 16'd0},
    '{CMD_CURSOR, 8'hFF, 8'hFF, 64'h0, CHK_BYTE, RS_INSTR, 8'hCF, 16'd0},
    '{CMD_CURSOR, 8'h07, 8'h80, 64'h0, CHK_MODEL, RS_INSTR, 8'h00, 16'd0},
    '{CMD_CHAR,   8'h00, 8'h00, 64'h0, CHK_MODEL, RS_INSTR, 8'h00, 16'd0},
    '{CMD_CHAR,   8'h07, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, CHK_MODEL, RS_INSTR, 8'h00, 16'd0},
    '{CMD_CHAR,   8'h08, 8'h00, 64'h1F11_0A04_0A11_1F00, CHK_MODEL, RS_INSTR, 8'h00, 16'd0},
    '{CMD_CHAR,   8'hFF, 8'h00, 64'h0123_4567_89AB_CDEF, CHK_MODEL, RS_INSTR, 8'h00, 16'd0},
    '{CMD_UNUSED_LO, 8'h00, 8'h00, 64'h0, CHK_NONE, RS_INSTR, 8'h00, 16'd0},
    '{CMD_UNUSED_HI, 8'hFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, CHK_NONE, RS_INSTR, 8'h00, 16'd0},
    '{CMD_UNUSED_MID, 8'h5A, 8'h01, 64'h0, CHK_NONE, RS_INSTR, 8'h00, 16'd0},
    '{CMD_WRITE,  8'h5A, 8'h00, 64'h0, CHK_MODEL, RS_INSTR, 8'h00, 16'd0},
    '{CMD_ERASE,  8'hFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, CHK_MODEL, RS_INSTR, 8'h00, 16'd0},
    '{CMD_INIT,   8'hFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, CHK_MODEL, RS_INSTR, 8'h00, 16'd0}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  // cmd[2:0], arg[10:3], row[18:11], bitmap[82:19], zero fill[87:83]
  logic [S_TDATA_W-1:0] s_axis_tdata_i = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  // reg_select[0], data_nibble[4:1], enable[5], hold_us[21:6], zero fill[23:22]
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  logic                 m_axis_tlast_o;

  pin_step_t   pin_steps_due [$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned sink_stall_pct = 0;

  char_lcd_4bit_sequencer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---- expected pin steps ----

  function automatic void queue_nibble(input logic rs, input logic [3:0] nib,
                                       input logic [15:0] extra);
    pin_steps_due.push_back('{rs, nib, 1'b0, PULSE_US, 1'b0});
    pin_steps_due.push_back('{rs, nib, 1'b1, PULSE_US, 1'b0});
    pin_steps_due.push_back('{rs, nib, 1'b0, SETTLE_US + extra, 1'b0});
  endfunction

  function automatic void queue_byte(input logic rs, input logic [7:0] b,
                                     input logic [15:0] extra);
    queue_nibble(rs, b[7:4], 16'd0);
    queue_nibble(rs, b[3:0], extra);
  endfunction

  function automatic void mark_last(input int unsigned start_len);
    if (pin_steps_due.size() > start_len) begin
      pin_steps_due[pin_steps_due.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void predict_pin_steps(input lcd_req_t r);
    int unsigned start_len;
    logic [2:0]  idx;
    logic [3:0]  col;
    logic [6:0]  base;
    start_len = pin_steps_due.size();
    case (r.cmd)
      CMD_INIT: begin
        pin_steps_due.push_back('{RS_INSTR, 4'h0, 1'b0, IDLE_US, 1'b0});
        queue_nibble(RS_INSTR, WAKE_NIB, WAKE1_EXTRA);
        queue_nibble(RS_INSTR, WAKE_NIB, WAKE2_EXTRA);
        queue_nibble(RS_INSTR, WAKE_NIB, WAKE2_EXTRA);
        queue_nibble(RS_INSTR, BUS4_NIB, BUS4_EXTRA);
        queue_byte(RS_INSTR, FUNC_SET, 16'd0);
        queue_byte(RS_INSTR, DISPLAY_OFF, 16'd0);
        queue_byte(RS_INSTR, CLEAR_INSTR, 16'(CLEAR_EXTRA_US));
        queue_byte(RS_INSTR, ENTRY_MODE, 16'd0);
        queue_byte(RS_INSTR, DISPLAY_ON, 16'd0);
      end
      CMD_ERASE: begin
        queue_byte(RS_INSTR, CLEAR_INSTR, 16'(CLEAR_EXTRA_US));
      end
      CMD_CHAR: begin
        idx = (r.arg > GLYPH_IDX_MAX) ? GLYPH_IDX_MAX : r.arg[2:0];
        queue_byte(RS_INSTR, CGRAM_INSTR | {2'b00, idx, 3'b000}, 16'd0);
        for (int i = 0; i < GLYPH_ROWS_DEF; i++) begin
          queue_byte(RS_DATA, r.bitmap[8*i +: 8], 16'd0);
        end
      end
      CMD_CURSOR: begin
        col  = (r.arg > COL_MAX) ? COL_MAX : r.arg[3:0];
        base = (r.row == 8'd0) ? 7'h00 : LINE2_BASE;
        queue_byte(RS_INSTR, DDRAM_INSTR | {1'b0, base + {3'b000, col}}, 16'd0);
      end
      CMD_WRITE: begin
        queue_byte(RS_DATA, r.arg, 16'd0);
      end
      default: ;
    endcase
    mark_last(start_len);
  endfunction

  function automatic lcd_req_t random_request();
    lcd_req_t    r;
    int unsigned pick;
    pick     = $urandom_range(99);
    r.arg    = ($urandom_range(1) == 0) ? 8'($urandom_range(20)) : 8'($urandom);
    r.row    = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom);
    r.bitmap = {$urandom, $urandom};
    if (pick < 8)       r.cmd = CMD_INIT;
    else if (pick < 18) r.cmd = CMD_ERASE;
    else if (pick < 33) r.cmd = CMD_CHAR;
    else if (pick < 53) r.cmd = CMD_CURSOR;
    else if (pick < 93) r.cmd = CMD_WRITE;
    else                r.cmd = 3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
    return r;
  endfunction

  // ---- request side ----

  task automatic send_request(input lcd_req_t r);
    if ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= S_TDATA_W'({r.bitmap, r.row, r.arg, r.cmd});
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pin_steps_due.size() != 0);
  endtask

  initial begin
    lcd_req_t    req;
    int unsigned start_len;
    int unsigned sent;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < STIM_ROWS; i++) begin
      req = '{STIM_TABLE[i].cmd, STIM_TABLE[i].arg, STIM_TABLE[i].row,
              STIM_TABLE[i].bitmap};
      send_request(req);
      start_len = pin_steps_due.size();
      case (STIM_TABLE[i].kind)
        CHK_MODEL: predict_pin_steps(req);
        CHK_BYTE: begin
          queue_byte(STIM_TABLE[i].want_rs, STIM_TABLE[i].want_byte,
                     STIM_TABLE[i].want_extra);
          mark_last(start_len);
        end
        default: ;
      endcase
    end
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = SENDER_PCT[ph];
      sink_stall_pct  = SINK_PCT[ph];
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        req = random_request();
        send_request(req);
        predict_pin_steps(req);
        sent++;
      end
      // hold off until every step of the phase is out
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pin_steps_due.size() == 0) begin
      $display("char_lcd_4bit_sequencer_test: clean");
    end else begin
      $display("char_lcd_4bit_sequencer_test: errors");
    end
    $finish;
  end

  // ---- step side ----

  function automatic void flag_field(input string name, input int unsigned want,
                                     input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    pin_step_t want;
    m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pin_steps_due.size() == 0) begin
        $display("%0t: unexpected step, expected none, actual tdata %0h tlast %0b",
                 $time, m_axis_tdata_o, m_axis_tlast_o);
        mismatches++;
      end else begin
        want = pin_steps_due.pop_front();
        flag_field("reg_select", 32'(want.rs), 32'(m_axis_tdata_o[0]));
        flag_field("data_nibble", 32'(want.nib), 32'(m_axis_tdata_o[4:1]));
        flag_field("enable", 32'(want.en), 32'(m_axis_tdata_o[5]));
        flag_field("hold_us", 32'(want.hold), 32'(m_axis_tdata_o[21:6]));
        flag_field("last", 32'(want.last), 32'(m_axis_tlast_o));
      end
    end
  end

  // no handshake on either side for too long means a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d steps outstanding",
                 $time, idle_cycles, pin_steps_due.size());
        $display("char_lcd_4bit_sequencer_test: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
